@@ src/rpn_digit_calculator_unit_assert.svh @@
// Assertion macros for the rpn calculator checker.
// Used by the checker module; no other dependencies.
`ifndef RPN_DIGIT_CALCULATOR_UNIT_ASSERT_SVH
`define RPN_DIGIT_CALCULATOR_UNIT_ASSERT_SVH
// implication checked every clock outside reset
`define RPN_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("rpn check failed");
// next-cycle implication checked outside reset
`define RPN_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("rpn check failed");
`endif

@@ src/rpn_pkg.sv @@
// Package for the rpn calculator: character codes, status codes, operation codes, command and status structs.
// No dependencies.
`default_nettype none
package rpn_pkg;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_NL    = 8'h0A;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;
	localparam logic [1:0] ST_DIVZ  = 2'd3;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// controller -> datapath commands
	typedef struct packed {
		logic       rd_top;   // latch next entry (read last cycle) into left register
		logic       rd_next;  // latch top entry into right register, read next entry
		logic       push_dig; // write digit at count
		logic       start_op; // launch arithmetic
		logic       wr_res;   // write result at count-2
		logic [1:0] op;
	} rpn_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic op_done;
		logic divz;
	} rpn_stat_t;
endpackage
`default_nettype wire

@@ src/rpn_datapath.sv @@
// Datapath of the rpn calculator: operand stack memory, operand registers,
// adder, registered multiplier and a radix-2 restoring divider. Uses rpn_pkg.
`default_nettype none
module rpn_datapath import rpn_pkg::*; #(
	parameter int STACK_DEPTH = 16,
	parameter int FRAC_BITS = 16,
	parameter int AW = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rpn_cmd_t      cmd,
	input  wire logic [AW-1:0] top_idx,
	input  wire logic [AW-1:0] nxt_idx,
	input  wire logic [AW-1:0] push_idx,
	input  wire logic [3:0]    digit,
	output rpn_stat_t          stat,
	output logic [31:0]        rd_data
);
	localparam int DW = 32 + FRAC_BITS;      // dividend width
	localparam int CW = $clog2(DW + 1);

	logic [31:0] mem [STACK_DEPTH];
	logic signed [31:0] left_q, right_q, res_q;
	logic [1:0] op_q;
	logic [2:0] phase_q;
	logic busy_q, done_q, divz_q;
	logic signed [63:0] prod_q;
	logic [DW-1:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic neg_q;
	logic [CW-1:0] cnt_q;

	function automatic logic signed [31:0] sat(input logic signed [64:0] x);
		if (x > 65'sd2147483647) return 32'sh7FFFFFFF;
		if (x < -65'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	// stack read and write ports
	always_ff @(posedge clk) begin
		if (cmd.push_dig)
			mem[push_idx] <= 32'(({28'd0, digit}) << FRAC_BITS);
		else if (done_q && cmd.wr_res)
			mem[nxt_idx] <= res_q;
		if (cmd.rd_next) rd_data <= mem[nxt_idx];
		else rd_data <= mem[top_idx];
	end

	// arithmetic sequencing
	logic signed [64:0] sum;
	logic signed [64:0] rnd;
	logic [32:0] trial;
	always_comb begin
		sum = (op_q == OP_ADD) ? 65'(left_q) + 65'(right_q) : 65'(left_q) - 65'(right_q);
		rnd = 65'(prod_q) + ((FRAC_BITS > 0) ? (65'sd1 <<< (FRAC_BITS - 1)) : 65'sd0);
		rnd = rnd >>> FRAC_BITS;
		trial = {rem_q[31:0], quo_q[DW-1]} - {1'b0, dvs_q};
	end

	logic [DW-1:0] qmag;
	logic signed [64:0] qs;
	always_comb begin
		qmag = quo_q;
		qs = neg_q ? -$signed(65'(qmag)) : $signed(65'(qmag));
	end

	// last busy cycle of the running operation
	logic fin;
	always_comb begin
		fin = 1'b0;
		if (busy_q && !cmd.start_op) begin
			case (op_q)
				OP_ADD, OP_SUB: fin = 1'b1;
				OP_MUL: fin = (phase_q == 3'd1);
				default: fin = (phase_q != 3'd0) && (cnt_q == '0 || divz_q);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			phase_q <= '0;
		end else begin
			done_q <= fin;
			if (cmd.start_op) begin
				busy_q <= 1'b1;
				phase_q <= 3'd0;
			end else if (busy_q) begin
				if (fin) busy_q <= 1'b0;
				else if (op_q == OP_MUL || phase_q == 3'd0) phase_q <= phase_q + 3'd1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.rd_next) right_q <= rd_data;
		if (cmd.rd_top) left_q <= rd_data;
		if (cmd.start_op) op_q <= cmd.op;
		if (busy_q) begin
			case (op_q)
				OP_ADD, OP_SUB: res_q <= sat(sum);
				OP_MUL: begin
					if (phase_q == 3'd0) prod_q <= left_q * right_q;
					else res_q <= sat(rnd);
				end
				default: begin
					if (phase_q == 3'd0) begin
						divz_q <= (right_q == 0);
						neg_q <= left_q[31] ^ right_q[31];
						dvs_q <= right_q[31] ? 32'(-right_q) : right_q;
						quo_q <= DW'({left_q[31] ? 32'(-left_q) : left_q}) << FRAC_BITS;
						rem_q <= '0;
						cnt_q <= CW'(DW);
						res_q <= left_q[31] ? 32'sh80000000 : 32'sh7FFFFFFF;
					end else if (cnt_q != '0 && !divz_q) begin
						if (!trial[32]) rem_q <= trial;
						else rem_q <= {rem_q[31:0], quo_q[DW-1]};
						quo_q <= {quo_q[DW-2:0], ~trial[32]};
						cnt_q <= cnt_q - CW'(1);
					end else if (!divz_q) res_q <= sat(qs);
				end
			endcase
		end
	end

	assign stat.op_done = done_q;
	assign stat.divz = divz_q && op_q == OP_DIV;
endmodule
`default_nettype wire

@@ src/rpn_ctrl.sv @@
// Controller of the rpn calculator: decodes characters, tracks stack count,
// sequences datapath commands and holds the result register. Uses rpn_pkg.
`default_nettype none
module rpn_ctrl import rpn_pkg::*; #(
	parameter int STACK_DEPTH = 16,
	parameter int AW = 4,
	parameter int CNTW = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    char_in,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [31:0]        value,
	output logic [1:0]         status,
	output rpn_cmd_t           cmd,
	output logic [AW-1:0]      top_idx,
	output logic [AW-1:0]      nxt_idx,
	output logic [AW-1:0]      push_idx,
	output logic [3:0]         digit,
	input  wire rpn_stat_t     stat,
	input  wire logic [31:0]   rd_data
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RDT  = 3'd1;
	localparam logic [2:0] S_RDN  = 3'd2;
	localparam logic [2:0] S_LAT  = 3'd3;
	localparam logic [2:0] S_OP   = 3'd4;
	localparam logic [2:0] S_WR   = 3'd5;
	localparam logic [2:0] S_EQ   = 3'd6;

	logic [2:0] state_q;
	logic [CNTW-1:0] cnt_q;
	logic [1:0] op_q;

	assign top_idx  = AW'(cnt_q - CNTW'(1));
	assign nxt_idx  = AW'(cnt_q - CNTW'(2));
	assign push_idx = AW'(cnt_q);
	assign digit    = char_in[3:0];
	assign in_ready = (state_q == S_IDLE) && !out_valid;

	logic acc, is_dig, is_op;
	always_comb begin
		acc = in_valid && in_ready;
		is_dig = char_in >= CH_ZERO && char_in <= CH_NINE;
		is_op = char_in == CH_PLUS || char_in == CH_MINUS || char_in == CH_MUL ||
			char_in == CH_DIV;
	end

	// command decode
	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		cmd.push_dig = acc && is_dig && cnt_q < CNTW'(STACK_DEPTH);
		cmd.rd_top = (state_q == S_RDN);
		cmd.rd_next = (state_q == S_RDT);
		cmd.start_op = (state_q == S_LAT);
		cmd.wr_res = (state_q == S_OP);
	end

	// sequence items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid <= 1'b0;
			value <= '0;
			status <= ST_OK;
			op_q <= OP_ADD;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (acc) begin
					if (is_dig) begin
						if (cnt_q < CNTW'(STACK_DEPTH)) cnt_q <= cnt_q + CNTW'(1);
						else begin
							out_valid <= 1'b1; value <= '0; status <= ST_OVER;
						end
					end else if (char_in == CH_NL) cnt_q <= '0;
					else if (char_in == CH_EQ) begin
						if (cnt_q == '0) begin
							out_valid <= 1'b1; value <= '0; status <= ST_UNDER;
						end else state_q <= S_EQ;
					end else if (is_op) begin
						if (cnt_q < CNTW'(2)) begin
							out_valid <= 1'b1; value <= '0; status <= ST_UNDER;
						end else begin
							state_q <= S_RDT;
							case (char_in)
								CH_PLUS:  op_q <= OP_ADD;
								CH_MINUS: op_q <= OP_SUB;
								CH_MUL:   op_q <= OP_MUL;
								default:  op_q <= OP_DIV;
							endcase
						end
					end
				end
				S_EQ: begin
					out_valid <= 1'b1; value <= rd_data; status <= ST_OK;
					state_q <= S_IDLE;
				end
				S_RDT: state_q <= S_RDN;
				S_RDN: state_q <= S_LAT;
				S_LAT: state_q <= S_OP;
				S_OP: if (stat.op_done) begin
					cnt_q <= cnt_q - CNTW'(1);
					if (stat.divz) begin
						out_valid <= 1'b1; value <= '0; status <= ST_DIVZ;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ src/rpn_digit_calculator_unit.sv @@
// Top level of the rpn calculator: controller plus datapath.
// Depends on rpn_pkg, rpn_ctrl, rpn_datapath.
//  channel | signals                     | direction
//  input   | in_valid in_ready char_in   | in
//  output  | out_valid out_ready value status | out
// Digit, newline and ignored characters are handled at acceptance; + - * / step through
// the read, latch and operate states, with / running in the serial divider.
// Underflow and overflow reports rise at the accepting edge, an '=' report in the cycle
// after it, a divide by zero report once the operation signals done in the operate state.
// A pending report blocks input until its transfer; no character is taken meanwhile.
// Reset clears the stack count and control state; stack contents are not cleared.
`default_nettype none
module rpn_digit_calculator_unit import rpn_pkg::*; #(
	parameter int STACK_DEPTH = 16,
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [31:0] value,
	output logic [1:0]       status
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CNTW = $clog2(STACK_DEPTH + 1);

	rpn_cmd_t cmd;
	rpn_stat_t stat;
	logic [AW-1:0] top_idx, nxt_idx, push_idx;
	logic [3:0] digit;
	logic [31:0] rd_data, value_raw;

	assign value = value_raw;

	rpn_ctrl #(.STACK_DEPTH(STACK_DEPTH), .AW(AW), .CNTW(CNTW)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .char_in, .out_valid, .out_ready,
		.value(value_raw), .status, .cmd, .top_idx, .nxt_idx, .push_idx, .digit,
		.stat, .rd_data
	);

	rpn_datapath #(.STACK_DEPTH(STACK_DEPTH), .FRAC_BITS(FRAC_BITS), .AW(AW)) u_dp (
		.clk, .arst_n, .cmd, .top_idx, .nxt_idx, .push_idx, .digit, .stat, .rd_data
	);
endmodule
`default_nettype wire

@@ src/rpn_checker.sv @@
// Port-level checker for the rpn calculator, bound to the top level.
// Depends on rpn_pkg and rpn_digit_calculator_unit_assert.svh.
`default_nettype none
`include "rpn_digit_calculator_unit_assert.svh"
module rpn_checker import rpn_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] value,
	input wire logic [1:0]  status
);
	`RPN_ASSERT_IMP(a_err_zero, out_valid && status != ST_OK, value == 32'd0)
	`RPN_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value))
	`RPN_ASSERT_IMP(a_no_take, out_valid, !in_ready)
endmodule

bind rpn_digit_calculator_unit rpn_checker u_chk (.*);
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking bench for the rpn calculator: character stream in, reports out.
// Depends on rpn_pkg and rpn_digit_calculator_unit; predicts results internally.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rpn_pkg::*;

	localparam int DEPTH = 16;
	localparam int FRAC = 16;
	localparam int TIMEOUT_CYCLES = 20000;

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         status;
	} report_t;

	typedef struct {
		logic [7:0]  ch;
		logic        has_exp;
		report_t     exp;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] char_in = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] value;
	logic [1:0] status;

	// model of the calculator state
	logic signed [31:0] calc_stack [DEPTH];
	int unsigned calc_depth = 0;
	report_t pending_reports [$];
	int errors = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;

	rpn_digit_calculator_unit #(.STACK_DEPTH(DEPTH), .FRAC_BITS(FRAC)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .char_in(char_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.value(value), .status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [31:0] clamp32(logic signed [65:0] x);
		if (x > 66'sd2147483647) return 32'sh7FFF_FFFF;
		if (x < -66'sd2147483648) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	// advance the stack model by one character, return 1 when a report is due
	function automatic bit calc_char(logic [7:0] ch, output report_t rep);
		logic signed [65:0] lhs, rhs, res;
		bit divz;
		divz = 1'b0;
		rep = '{value: 32'sd0, status: ST_OK};
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			if (calc_depth >= DEPTH) begin
				rep.status = ST_OVER;
				return 1'b1;
			end
			calc_stack[calc_depth] = 32'(ch - CH_ZERO) << FRAC;
			calc_depth++;
			return 1'b0;
		end
		if (ch == CH_NL) begin
			calc_depth = 0;
			return 1'b0;
		end
		if (ch == CH_EQ) begin
			if (calc_depth == 0) rep.status = ST_UNDER;
			else rep.value = calc_stack[calc_depth-1];
			return 1'b1;
		end
		if (ch != CH_PLUS && ch != CH_MINUS && ch != CH_MUL && ch != CH_DIV) return 1'b0;
		if (calc_depth < 2) begin
			rep.status = ST_UNDER;
			return 1'b1;
		end
		rhs = calc_stack[calc_depth-1];
		lhs = calc_stack[calc_depth-2];
		case (ch)
			CH_PLUS:  res = lhs + rhs;
			CH_MINUS: res = lhs - rhs;
			// round half up: add half an LSB, then arithmetic shift floors
			CH_MUL:   res = (lhs * rhs + (66'sd1 <<< (FRAC-1))) >>> FRAC;
			default: begin
				if (rhs == 0) begin
					divz = 1'b1;
					res = (lhs < 0) ? -66'sd2147483648 : 66'sd2147483647;
				end else begin
					res = (lhs <<< FRAC) / rhs;
				end
			end
		endcase
		calc_depth--;
		calc_stack[calc_depth-1] = clamp32(res);
		if (divz) begin
			rep.status = ST_DIVZ;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// receiver: random stall, or long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// check each report transfer against the oldest prediction
	always @(posedge clk) begin
		report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected report value=%0d status=%0d", value, status);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				if (status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, status);
					errors++;
				end
				if (value !== want.value) begin
					$error("value expected %0d actual %0d", want.value, value);
					errors++;
				end
			end
		end
	end

	// watchdog on transfers
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= TIMEOUT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// offer one character, predict at acceptance
	task automatic send_char(logic [7:0] ch, bit has_exp = 1'b0, report_t exp = '0);
		report_t rep;
		bit due;
		// idle the sender for a random number of cycles
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		char_in <= ch;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		due = calc_char(ch, rep);
		if (due) begin
			if (has_exp && rep !== exp) begin
				$error("table row char=%02h value expected %0d predicted %0d, status expected %0d predicted %0d",
					ch, exp.value, rep.value, exp.status, rep.status);
				errors++;
			end
			pending_reports.push_back(rep);
		end
		@(negedge clk);
	endtask

	task automatic drain_reports();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 45) return CH_ZERO + 8'($urandom_range(9));
		if (r < 55) return CH_PLUS;
		if (r < 63) return CH_MINUS;
		if (r < 73) return CH_MUL;
		if (r < 81) return CH_DIV;
		if (r < 90) return CH_EQ;
		if (r < 94) return CH_NL;
		return 8'($urandom_range(255));
	endfunction

	row_t directed [$];
	function automatic row_t mk(logic [7:0] ch, logic has = 1'b0,
			logic [31:0] v = 0, logic [1:0] s = ST_OK);
		row_t r;
		r.ch = ch; r.has_exp = has; r.exp = '{value: v, status: s};
		return r;
	endfunction

	initial begin
		int phase;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: underflow after reset, extremes, every operator, errors
		directed = '{
			mk(CH_EQ, 1, 0, ST_UNDER), mk(CH_PLUS, 1, 0, ST_UNDER),
			mk(CH_ZERO + 9), mk(CH_EQ, 1, 32'h0009_0000, ST_OK),
			mk(CH_MUL, 1, 0, ST_UNDER), mk(CH_ZERO), mk(CH_DIV, 1, 0, ST_DIVZ),
			mk(CH_EQ, 1, 32'h7FFF_FFFF, ST_OK), mk(CH_ZERO + 2), mk(CH_MUL),
			mk(CH_EQ, 1, 32'h7FFF_FFFF, ST_OK), mk(CH_ZERO + 7), mk(CH_MINUS),
			mk(CH_EQ), mk(8'hFF), mk(8'h00), mk(CH_NL), mk(CH_ZERO),
			mk(CH_ZERO + 3), mk(CH_MINUS), mk(CH_ZERO), mk(CH_DIV, 1, 0, ST_DIVZ),
			mk(CH_EQ, 1, 32'h8000_0000, ST_OK), mk(CH_NL)
		};
		foreach (directed[i]) send_char(directed[i].ch, directed[i].has_exp, directed[i].exp);
		// fill past the depth: overflow
		for (int i = 0; i < DEPTH + 1; i++) send_char(CH_ZERO + 8'(i % 10));
		send_char(CH_ZERO + 5, 1, '{value: 0, status: ST_OVER});
		for (int i = 0; i < DEPTH - 1; i++) send_char(CH_DIV);
		send_char(CH_EQ);
		send_char(CH_NL);
		drain_reports();

		// walk the idling phases with random expressions
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			for (int n = 0; n < 290; n++) send_char(pick_char());
			drain_reports();
		end

		// receiver holds off while the sender keeps offering
		send_idle_pct = 0;
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			begin
				for (int n = 0; n < 20; n++) send_char(CH_EQ);
			end
		join
		// full bit sweep of the character field
		for (int b = 0; b < 8; b++) begin
			send_char(8'(1 << b));
			send_char(~8'(1 << b));
		end
		send_char(CH_EQ);
		drain_reports();

		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+src
src/rpn_pkg.sv
src/rpn_datapath.sv
src/rpn_ctrl.sv
src/rpn_digit_calculator_unit.sv
src/rpn_checker.sv
sim/tb_top.sv
